>>> rtl/fcvt_pkg.sv
// ----------------------------------------------------------------------------
// fcvt_pkg: shared types and codes for the float format converter
// Operation codes and field widths used by the datapath and the top level.
// ----------------------------------------------------------------------------
package fcvt_pkg;

  // Operation select carried on tuser
  typedef logic [1:0] op_t;

  localparam op_t OP_F16_TO_F32 = 2'd0;
  localparam op_t OP_B16_TO_F32 = 2'd1;
  localparam op_t OP_F32_TO_F16 = 2'd2;
  localparam op_t OP_F32_TO_B16 = 2'd3;

  // binary32 field layout
  localparam int unsigned F32_MAN_W = 23;
  localparam int unsigned F32_EXP_W = 8;

  // binary16 field layout
  localparam int unsigned F16_MAN_W = 10;
  localparam int unsigned F16_EXP_W = 5;

  // Bias difference between binary32 and binary16 exponents
  localparam logic [7:0] BIAS_DIFF = 8'd112;

  // Split of a binary32 word into its fields
  typedef struct packed {
    logic                 sign;
    logic [F32_EXP_W-1:0] exp;
    logic [F32_MAN_W-1:0] man;
  } f32_t;

endpackage

>>> rtl/fcvt_widen.sv
// ----------------------------------------------------------------------------
// fcvt_widen: 16-bit to binary32 widening
// binary16 is converted exactly (subnormals normalized, inf/NaN payload kept);
// bfloat16 is placed in the upper half of the word.
// ----------------------------------------------------------------------------
module fcvt_widen (
  input  fcvt_pkg::op_t op,
  input  logic [15:0]   src,
  output logic [31:0]   dst
);

  logic       h_sign;
  logic [4:0] h_exp;
  logic [9:0] h_man;
  logic [3:0] lead_pos;
  logic [3:0] norm_sh;
  logic [9:0] norm_man;
  logic [7:0] norm_exp;
  logic [31:0] half_res;

  assign h_sign = src[15];
  assign h_exp  = src[14:10];
  assign h_man  = src[9:0];

  // Position of the leading one in a subnormal mantissa
  always_comb begin
    lead_pos = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (h_man[i]) begin
        lead_pos = 4'(i);
      end
    end
  end

  // Normalize: move the leading one to the hidden-bit position
  assign norm_sh  = 4'd10 - lead_pos;
  assign norm_man = h_man << norm_sh;
  assign norm_exp = 8'd103 + {4'd0, lead_pos};

  // binary16 classes
  always_comb begin
    if (h_exp == 5'd0) begin
      if (h_man == 10'd0) begin
        half_res = {h_sign, 31'd0};
      end else begin
        half_res = {h_sign, norm_exp, norm_man, 13'd0};
      end
    end else if (h_exp == 5'h1F) begin
      half_res = {h_sign, 8'hFF, h_man, 13'd0};
    end else begin
      half_res = {h_sign, {3'd0, h_exp} + fcvt_pkg::BIAS_DIFF, h_man, 13'd0};
    end
  end

  // bfloat16 is a plain shift
  assign dst = (op == fcvt_pkg::OP_B16_TO_F32) ? {src, 16'd0} : half_res;

endmodule

>>> rtl/fcvt_narrow.sv
// ----------------------------------------------------------------------------
// fcvt_narrow: binary32 to 16-bit narrowing
// Round to nearest even into binary16 (subnormal, overflow and NaN handling)
// or into bfloat16 (NaNs quieted). Result is zero-extended to 32 bits.
// ----------------------------------------------------------------------------
module fcvt_narrow (
  input  fcvt_pkg::op_t op,
  input  logic [31:0]   src,
  output logic [31:0]   dst
);

  fcvt_pkg::f32_t f;

  logic [23:0] full_man;
  logic [7:0]  sub_sh8;
  logic [4:0]  sub_sh;
  logic [23:0] sub_shifted;
  logic [23:0] sub_mask;
  logic        sub_sticky;
  logic [10:0] sub_hm;
  logic        sub_up;
  logic [14:0] nrm_mag;
  logic        nrm_up;
  logic [15:0] half_res;

  logic [31:0] bf_sum;
  logic        bf_nan;
  logic [15:0] bf_res;

  assign f        = src;
  assign full_man = {1'b1, f.man};

  // Subnormal result: shift right by (125 - exp) to reach the guard bit
  assign sub_sh8     = 8'd125 - f.exp;
  assign sub_sh      = sub_sh8[4:0];
  assign sub_shifted = full_man >> sub_sh;
  assign sub_mask    = (24'd1 << sub_sh) - 24'd1;
  assign sub_sticky  = |(full_man & sub_mask);
  assign sub_hm      = sub_shifted[11:1];
  assign sub_up      = sub_shifted[0] & (sub_sticky | sub_hm[0]);

  // Normal result: drop 13 mantissa bits, ties to even
  assign nrm_up  = f.man[12] & ((|f.man[11:0]) | f.man[13]);
  assign nrm_mag = {f.exp[4:0] - 5'd16, f.man[22:13]} + {14'd0, nrm_up};

  // binary16 range selection on the source exponent
  always_comb begin
    if (f.exp == 8'hFF) begin
      half_res = {f.sign, 5'h1F, (f.man != 23'd0), 9'd0};
    end else if (f.exp >= 8'd143) begin
      half_res = {f.sign, 5'h1F, 10'd0};
    end else if (f.exp >= 8'd113) begin
      half_res = {f.sign, nrm_mag};
    end else if (f.exp >= 8'd102) begin
      half_res = {f.sign, 4'd0, sub_hm + {10'd0, sub_up}};
    end else begin
      half_res = {f.sign, 15'd0};
    end
  end

  // bfloat16: quiet NaNs, otherwise round to nearest even on the upper half
  assign bf_nan = src[30:0] > 31'h7F800000;
  assign bf_sum = src + 32'h0000_7FFF + {31'd0, src[16]};
  assign bf_res = bf_nan ? (src[31:16] | 16'h0040) : bf_sum[31:16];

  assign dst = {16'd0, (op == fcvt_pkg::OP_F32_TO_B16) ? bf_res : half_res};

endmodule

>>> rtl/fp32_fp16_bf16_converter.sv
// ----------------------------------------------------------------------------
// fp32_fp16_bf16_converter: binary32 / binary16 / bfloat16 format converter
// Two-register pipeline around a combinational conversion datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tdata carries the raw operand, tuser the operation
//   (0 fp16->fp32, 1 bf16->fp32, 2 fp32->fp16, 3 fp32->bf16). 16-bit sources
//   sit in tdata[15:0]; the upper bits are ignored for them.
//   Master stream: tdata carries the raw result; 16-bit results come
//   zero-extended to 32 bits.
//   Path: an accepted transaction is held in the input register, converted
//   into the result register once that register is free, and shown on the
//   master side from there.
//   Throughput: one transaction per cycle while the receiver keeps tready
//   high, set by the single conversion stage between the two registers.
//   Stall: when the receiver holds tready low, the result register holds
//   and the input register still takes one more transaction; tready on the
//   slave side drops only when both registers are full.
//   Reset: rst clears both valid flags; nothing else is kept.
// ----------------------------------------------------------------------------
module fp32_fp16_bf16_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] operand_bits
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] result_bits
);

  // Input register
  logic          in_valid;
  fcvt_pkg::op_t in_op;
  logic [31:0]   in_bits;

  // Result register
  logic          out_valid;
  logic [31:0]   out_bits;

  logic          out_free;
  logic          advance;
  logic [31:0]   wide_res;
  logic [31:0]   narrow_res;
  logic [31:0]   conv_res;

  // Flow control
  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  // Input register load
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= s_axis_tuser;
      in_bits <= s_axis_tdata;
    end
  end

  // Conversion datapath
  fcvt_widen u_widen (
    .op  (in_op),
    .src (in_bits[15:0]),
    .dst (wide_res)
  );

  fcvt_narrow u_narrow (
    .op  (in_op),
    .src (in_bits),
    .dst (narrow_res)
  );

  always_comb begin
    unique case (in_op)
      fcvt_pkg::OP_F16_TO_F32,
      fcvt_pkg::OP_B16_TO_F32: conv_res = wide_res;
      default:                 conv_res = narrow_res;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_bits <= conv_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_bits;

`ifndef SYNTHESIS
  // A transaction leaving the input register lands in the result register
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register not loaded after advance");

  // Stalled output keeps the pending input transaction in place
  a_input_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !m_axis_tready |=> in_valid && $stable(in_bits))
    else $error("input register changed while stalled");

  // Narrowing results are zero-extended
  a_narrow_zext: assert property (@(posedge clk) disable iff (rst)
    advance && in_op[1] |=> out_bits[31:16] == 16'd0)
    else $error("narrowed result has upper bits set");

  // Backpressure only when both registers are occupied
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && out_valid)
    else $error("slave ready low with free register");
`endif

endmodule

>>> test/fp32_fp16_bf16_converter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fp32_fp16_bf16_converter_tb: stream testbench for the float format converter
// Drives conversion requests on the slave stream and checks every result on
// the master stream against a bit-exact software predictor. The run goes from
// directed corner cases to random bursts under several idle and stall mixes,
// including a long receiver hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module fp32_fp16_bf16_converter_tb;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD      = 200;
  localparam int unsigned BURST_ITEMS    = 260;

  // One conversion in flight: request and the bits it must produce
  typedef struct {
    fcvt_pkg::op_t op;
    logic [31:0]   operand;
    logic [31:0]   result;
  } conv_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  conv_rec_t   pending_convs[$];
  int unsigned error_count     = 0;
  int unsigned results_checked = 0;
  int unsigned op_counts[4]    = '{default: 0};
  int unsigned tx_idle_pct     = 0;
  int unsigned rx_stall_pct    = 0;
  int unsigned rx_hold_request = 0;
  int unsigned rx_hold_served  = 0;
  int unsigned rx_hold_left    = 0;
  int unsigned quiet_cycles    = 0;

  fp32_fp16_bf16_converter DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] operand_bits
    .s_axis_tuser  (s_axis_tuser),   // [1:0] operation
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [31:0] result_bits
  );

  // Clock
  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // binary16 -> binary32, exact; subnormals are normalized
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [10:0]  man;
    int unsigned  lz;
    man = {1'b0, h[9:0]};
    lz  = 0;
    if (h[14:10] == 5'h00) begin
      if (man == '0) return {h[15], 31'b0};
      while (!man[10]) begin
        man = man << 1;
        lz++;
      end
      return {h[15], 8'(113 - lz), man[9:0], 13'b0};
    end
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'b0};
    return {h[15], 8'({3'b0, h[14:10]}) + fcvt_pkg::BIAS_DIFF, h[9:0], 13'b0};
  endfunction

  // binary32 -> binary16, round to nearest even
  function automatic logic [15:0] narrow_half(input logic [31:0] x);
    int          e;
    int          sh;
    logic [23:0] mant;
    logic [23:0] hm;
    logic [23:0] rem;
    logic [23:0] half;
    logic [15:0] r;
    if (x[30:23] == 8'hFF) return {x[31], (x[22:0] != '0) ? 15'h7E00 : 15'h7C00};
    e = int'(x[30:23]) - 112;
    if (e >= 31) return {x[31], 15'h7C00};
    if (e <= 0) begin
      // subnormal result, or flush to signed zero
      if (e < -10) return {x[31], 15'h0000};
      mant = {1'b1, x[22:0]};
      sh   = 14 - e;
      hm   = mant >> sh;
      rem  = mant & ((24'd1 << sh) - 24'd1);
      half = 24'd1 << (sh - 1);
      if (rem > half || (rem == half && hm[0])) hm = hm + 24'd1;
      return {x[31], hm[14:0]};
    end
    r = {x[31], 5'(e), x[22:13]};
    if (x[12:0] > 13'h1000 || (x[12:0] == 13'h1000 && r[0])) r = r + 16'd1;
    return r;
  endfunction

  // binary32 -> bfloat16, round to nearest even, NaNs quieted
  function automatic logic [15:0] narrow_brain(input logic [31:0] x);
    logic [31:0] sum;
    if (x[30:0] > 31'h7F800000) return x[31:16] | 16'h0040;
    sum = x + 32'h0000_7FFF + {31'b0, x[16]};
    return sum[31:16];
  endfunction

  function automatic logic [31:0] predict_conversion(input fcvt_pkg::op_t op,
                                                     input logic [31:0] v);
    case (op)
      fcvt_pkg::OP_F16_TO_F32: return widen_half(v[15:0]);
      fcvt_pkg::OP_B16_TO_F32: return {v[15:0], 16'b0};
      fcvt_pkg::OP_F32_TO_F16: return {16'b0, narrow_half(v)};
      default:                 return {16'b0, narrow_brain(v)};
    endcase
  endfunction

  // ------------------------------------------------------- scoreboard/monitor

  // Results are checked before new requests are queued at the same edge
  always @(posedge clk) begin : check_results
    conv_rec_t rec;
    conv_rec_t req;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_convs.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        end else begin
          rec = pending_convs.pop_front();
          results_checked++;
          if (m_axis_tdata !== rec.result) begin
            error_count++;
            $display("%0t: mismatch op %0d operand %h: expected %h, actual %h",
                     $time, rec.op, rec.operand, rec.result, m_axis_tdata);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req.op      = s_axis_tuser;
        req.operand = s_axis_tdata;
        req.result  = predict_conversion(s_axis_tuser, s_axis_tdata);
        pending_convs.push_back(req);
        op_counts[s_axis_tuser]++;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rx_hold_request != rx_hold_served) begin
      rx_hold_served <= rx_hold_request;
      rx_hold_left   <= LONG_HOLD;
      m_axis_tready  <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left  <= rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $time, pending_convs.size());
      $display("fp32_fp16_bf16_converter_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------ stimulus

  task automatic send_conv(input fcvt_pkg::op_t op, input logic [31:0] bits);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bits;
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Sender pauses until every expected result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_convs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Operands biased toward exponent edges and rounding boundaries
  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(9))
      3, 4: v[30:23] = 8'($urandom_range(145, 98));
      5:    v[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
      6:    v[12:0]  = 13'h0FFF + 13'($urandom_range(2));
      7:    v[15:0]  = 16'h7FFF + 16'($urandom_range(2));
      8:    v[14:10] = $urandom_range(1) ? 5'h1F : 5'h00;
      9:    begin
              v[30:23] = 8'd142;
              v[22:13] = 10'h3FF;
            end
      default: ;
    endcase
    return v;
  endfunction

  task automatic run_random_burst(input int unsigned count);
    repeat (count) send_conv(fcvt_pkg::op_t'($urandom_range(3)), random_operand());
    drain_results();
  endtask

  task automatic test_directed_cases();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    // half to single: zeros, subnormals, largest finite, inf, NaN, junk upper bits
    send_conv(fcvt_pkg::OP_F16_TO_F32, 32'h0000_0000);
    send_conv(fcvt_pkg::OP_F16_TO_F32, 32'hFFFF_8000);
    send_conv(fcvt_pkg::OP_F16_TO_F32, 32'h0000_0001);
    send_conv(fcvt_pkg::OP_F16_TO_F32, 32'h0000_83FF);
    send_conv(fcvt_pkg::OP_F16_TO_F32, 32'h0000_7BFF);
    send_conv(fcvt_pkg::OP_F16_TO_F32, 32'h0000_7C00);
    send_conv(fcvt_pkg::OP_F16_TO_F32, 32'h1234_7E01);
    // bfloat16 widening ignores the upper half
    send_conv(fcvt_pkg::OP_B16_TO_F32, 32'hFFFF_FFFF);
    send_conv(fcvt_pkg::OP_B16_TO_F32, 32'hABCD_1234);
    // single to half: NaN, inf, overflow, round to inf, underflow tie, subnormals
    send_conv(fcvt_pkg::OP_F32_TO_F16, 32'h7FC0_0001);
    send_conv(fcvt_pkg::OP_F32_TO_F16, 32'hFF80_0000);
    send_conv(fcvt_pkg::OP_F32_TO_F16, 32'h4780_0000);
    send_conv(fcvt_pkg::OP_F32_TO_F16, 32'h477F_F000);
    send_conv(fcvt_pkg::OP_F32_TO_F16, 32'hB300_0000);
    send_conv(fcvt_pkg::OP_F32_TO_F16, 32'h3300_0001);
    send_conv(fcvt_pkg::OP_F32_TO_F16, 32'h0000_0001);
    send_conv(fcvt_pkg::OP_F32_TO_F16, 32'h387F_F000);
    send_conv(fcvt_pkg::OP_F32_TO_F16, 32'h3F80_1000);
    send_conv(fcvt_pkg::OP_F32_TO_F16, 32'h3F80_3000);
    send_conv(fcvt_pkg::OP_F32_TO_F16, 32'hFFFF_FFFF);
    // single to bfloat16: NaN quieting, inf, rounding overflow, ties
    send_conv(fcvt_pkg::OP_F32_TO_B16, 32'h7F80_0001);
    send_conv(fcvt_pkg::OP_F32_TO_B16, 32'hFF80_0000);
    send_conv(fcvt_pkg::OP_F32_TO_B16, 32'h7F7F_FFFF);
    send_conv(fcvt_pkg::OP_F32_TO_B16, 32'h3F80_8000);
    send_conv(fcvt_pkg::OP_F32_TO_B16, 32'h3F81_8000);
    drain_results();
  endtask

  task automatic test_full_rate();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    run_random_burst(BURST_ITEMS);
  endtask

  task automatic test_sender_gaps();
    tx_idle_pct  = 58;
    rx_stall_pct = 0;
    run_random_burst(BURST_ITEMS);
  endtask

  task automatic test_receiver_stalls();
    tx_idle_pct  = 0;
    rx_stall_pct = 58;
    run_random_burst(BURST_ITEMS);
  endtask

  task automatic test_mixed_gaps();
    tx_idle_pct  = 12;
    rx_stall_pct = 12;
    run_random_burst(BURST_ITEMS);
  endtask

  // Receiver holds off while the sender keeps offering, filling the pipeline
  task automatic test_output_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_request++;
    run_random_burst(BURST_ITEMS);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_full_rate();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_gaps();
    test_output_backpressure();

    repeat (8) @(posedge clk);
    $display("Checked %0d conversions: fp16->fp32 %0d, bf16->fp32 %0d,",
             results_checked, op_counts[fcvt_pkg::OP_F16_TO_F32],
             op_counts[fcvt_pkg::OP_B16_TO_F32]);
    $display("  fp32->fp16 %0d, fp32->bf16 %0d",
             op_counts[fcvt_pkg::OP_F32_TO_F16], op_counts[fcvt_pkg::OP_F32_TO_B16]);
    $display("Covered corner cases, full rate, sender gaps, receiver stalls and a long hold-off");
    if (error_count == 0 && pending_convs.size() == 0) begin
      $display("fp32_fp16_bf16_converter_tb passed");
    end else begin
      $display("%0d errors, %0d results outstanding", error_count, pending_convs.size());
      $display("fp32_fp16_bf16_converter_tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/fcvt_pkg.sv
rtl/fcvt_widen.sv
rtl/fcvt_narrow.sv
rtl/fp32_fp16_bf16_converter.sv
test/fp32_fp16_bf16_converter_tb.sv
